FILE: sv/cvp_pkg.sv
// shared constants, register codes and types of the conv/relu/maxpool stream block
package cvp_pkg;

  localparam int DEF_MAX_COLUMNS = 2048;
  localparam int DEF_PIXEL_BITS  = 16;

  localparam int DIM_BITS       = 12;
  localparam int WEIGHT_BITS    = 16;
  localparam int KERNEL_TAPS    = 3;
  localparam int ROW_BITS       = KERNEL_TAPS * WEIGHT_BITS;
  localparam int BIAS_BITS      = 16;
  localparam int FRAC_BITS      = 8;
  localparam int RESULT_BITS    = 15;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = ROW_BITS;

  localparam logic [DIM_BITS-1:0] RESET_WIDTH  = 12'd1920;
  localparam logic [DIM_BITS-1:0] RESET_HEIGHT = 12'd1080;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_KERNEL_TOP    = 3'd2,
    REG_KERNEL_MIDDLE = 3'd3,
    REG_KERNEL_BOTTOM = 3'd4,
    REG_CONV_BIAS     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic conv_en;
    logic row_odd;
    logic col_odd;
    logic frame_end;
  } item_meta_t;

  typedef struct packed {
    logic [ROW_BITS-1:0]         top;
    logic [ROW_BITS-1:0]         middle;
    logic [ROW_BITS-1:0]         bottom;
    logic signed [BIAS_BITS-1:0] bias;
  } conv_cfg_t;

endpackage

FILE: sv/cvp_if.sv
// stream and configuration channel interfaces
interface cvp_pixel_if import cvp_pkg::*; #(
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [PIXEL_BITS-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface cvp_result_if import cvp_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [RESULT_BITS-1:0] pooled_value;
  logic                   frame_last;

  modport source (output valid, output pooled_value, output frame_last, input ready);
  modport sink   (input valid, input pooled_value, input frame_last, output ready);
endinterface

interface cvp_cfg_if import cvp_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/cvp_line_ram.sv
// one-line store with registered read and write-to-read bypass
module cvp_line_ram import cvp_pkg::*; #(
  parameter int  DEPTH = DEF_MAX_COLUMNS,
  parameter int  WIDTH = DEF_PIXEL_BITS,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && wr_addr == rd_addr) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

FILE: sv/cvp_conv.sv
// 3x3 window, products, row sums and relu/saturation, three pipeline stages
module cvp_conv import cvp_pkg::*; #(
  parameter int  MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int  PIXEL_BITS  = DEF_PIXEL_BITS,
  localparam int COL_BITS    = $clog2(MAX_COLUMNS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  conv_cfg_t                    conv_cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [COL_BITS-1:0]          in_col,
  input  item_meta_t                   in_meta,
  input  logic signed [PIXEL_BITS-1:0] in_pixel,
  input  logic [PIXEL_BITS-1:0]        in_upper,
  input  logic [PIXEL_BITS-1:0]        in_lower,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [COL_BITS-1:0]          out_col,
  output item_meta_t                   out_meta,
  output logic [RESULT_BITS-1:0]       out_value
);

  localparam int PROD_BITS   = WEIGHT_BITS + PIXEL_BITS;
  localparam int ROWSUM_BITS = PROD_BITS + 2;
  localparam int ACC_BITS    = PROD_BITS + 4;
  localparam int SCALED_BITS = BIAS_BITS + FRAC_BITS;

  logic signed [PIXEL_BITS-1:0]  window      [KERNEL_TAPS][KERNEL_TAPS];
  logic signed [PIXEL_BITS-1:0]  window_next [KERNEL_TAPS][KERNEL_TAPS];
  logic signed [WEIGHT_BITS-1:0] weight      [KERNEL_TAPS][KERNEL_TAPS];
  logic signed [PROD_BITS-1:0]   prod        [KERNEL_TAPS][KERNEL_TAPS];
  logic signed [ROWSUM_BITS-1:0] rowsum      [KERNEL_TAPS];
  logic signed [ROWSUM_BITS-1:0] rowsum_next [KERNEL_TAPS];
  logic signed [SCALED_BITS-1:0] bias_scaled;
  logic signed [ACC_BITS-1:0]    acc;
  logic [RESULT_BITS-1:0]        value_next;

  logic                p_valid, q_valid, c_valid;
  logic                p_ready, q_ready, c_ready;
  logic [COL_BITS-1:0] p_col, q_col, c_col;
  item_meta_t          p_meta, q_meta, c_meta;
  logic [RESULT_BITS-1:0] c_value;

  assign p_ready  = !p_valid || q_ready;
  assign q_ready  = !q_valid || c_ready;
  assign c_ready  = !c_valid || out_ready;
  assign in_ready = p_ready;

  assign out_valid = c_valid;
  assign out_col   = c_col;
  assign out_meta  = c_meta;
  assign out_value = c_value;

  // column 0 is the oldest pixel of each row
  always_comb begin
    for (int c = 0; c < KERNEL_TAPS; c++) begin
      weight[0][c] = conv_cfg.top[c*WEIGHT_BITS +: WEIGHT_BITS];
      weight[1][c] = conv_cfg.middle[c*WEIGHT_BITS +: WEIGHT_BITS];
      weight[2][c] = conv_cfg.bottom[c*WEIGHT_BITS +: WEIGHT_BITS];
    end
  end

  always_comb begin
    for (int r = 0; r < KERNEL_TAPS; r++) begin
      for (int c = 0; c < KERNEL_TAPS - 1; c++) begin
        window_next[r][c] = window[r][c+1];
      end
    end
    window_next[0][KERNEL_TAPS-1] = in_upper;
    window_next[1][KERNEL_TAPS-1] = in_lower;
    window_next[2][KERNEL_TAPS-1] = in_pixel;
  end

  assign bias_scaled = {conv_cfg.bias, {FRAC_BITS{1'b0}}};

  always_comb begin
    for (int r = 0; r < KERNEL_TAPS; r++) begin
      rowsum_next[r] = '0;
      for (int c = 0; c < KERNEL_TAPS; c++) begin
        rowsum_next[r] = rowsum_next[r] + ROWSUM_BITS'(prod[r][c]);
      end
    end
    rowsum_next[0] = rowsum_next[0] + ROWSUM_BITS'(bias_scaled);
  end

  always_comb begin
    acc = ACC_BITS'(rowsum[0]) + ACC_BITS'(rowsum[1]) + ACC_BITS'(rowsum[2]);
    if (!q_meta.conv_en || acc[ACC_BITS-1]) begin
      value_next = '0;
    end else if (|acc[ACC_BITS-2:FRAC_BITS+RESULT_BITS]) begin
      value_next = '1;
    end else begin
      value_next = acc[FRAC_BITS+RESULT_BITS-1:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      q_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (p_ready) begin
        p_valid <= in_valid;
      end
      if (q_ready) begin
        q_valid <= p_valid;
      end
      if (c_ready) begin
        c_valid <= q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && p_ready) begin
      window <= window_next;
      for (int r = 0; r < KERNEL_TAPS; r++) begin
        for (int c = 0; c < KERNEL_TAPS; c++) begin
          prod[r][c] <= weight[r][c] * window_next[r][c];
        end
      end
      p_col  <= in_col;
      p_meta <= in_meta;
    end
    if (p_valid && q_ready) begin
      rowsum <= rowsum_next;
      q_col  <= p_col;
      q_meta <= p_meta;
    end
    if (q_valid && c_ready) begin
      c_value <= value_next;
      c_col   <= q_col;
      c_meta  <= q_meta;
    end
  end

endmodule

FILE: sv/cvp_pool.sv
// pooling line store, 2x2 window, maximum and output register
module cvp_pool import cvp_pkg::*; #(
  parameter int  MAX_COLUMNS = DEF_MAX_COLUMNS,
  localparam int COL_BITS    = $clog2(MAX_COLUMNS)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COL_BITS-1:0]    in_col,
  input  item_meta_t             in_meta,
  input  logic [RESULT_BITS-1:0] in_value,
  cvp_result_if.source           results
);

  logic                   d_valid, d_go, d_emit, out_free;
  logic [COL_BITS-1:0]    d_col;
  item_meta_t             d_meta;
  logic [RESULT_BITS-1:0] d_value;
  logic [RESULT_BITS-1:0] pool_rd;
  logic [RESULT_BITS-1:0] pool_window      [4];
  logic [RESULT_BITS-1:0] pool_window_next [4];
  logic [RESULT_BITS-1:0] max_a, max_b, max_all;
  logic                   out_valid, out_last;
  logic [RESULT_BITS-1:0] out_value;

  assign d_emit   = d_meta.row_odd && d_meta.col_odd;
  assign out_free = !out_valid || results.ready;
  assign d_go     = d_valid && (!d_emit || out_free);
  assign in_ready = !d_valid || !d_emit || out_free;

  cvp_line_ram #(
    .DEPTH (MAX_COLUMNS),
    .WIDTH (RESULT_BITS)
  ) u_pool_line (
    .clk     (clk),
    .wr_en   (d_go && !d_meta.row_odd),
    .wr_addr (d_col),
    .wr_data (d_value),
    .rd_en   (in_valid && in_ready),
    .rd_addr (in_col),
    .rd_data (pool_rd)
  );

  always_comb begin
    pool_window_next[0] = pool_window[2];
    pool_window_next[1] = pool_window[3];
    pool_window_next[2] = pool_rd;
    pool_window_next[3] = d_value;
    max_a   = (pool_window_next[1] > pool_window_next[0]) ? pool_window_next[1]
                                                          : pool_window_next[0];
    max_b   = (pool_window_next[3] > pool_window_next[2]) ? pool_window_next[3]
                                                          : pool_window_next[2];
    max_all = (max_b > max_a) ? max_b : max_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        d_valid <= in_valid;
      end
      if (d_go && d_emit) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      d_col   <= in_col;
      d_meta  <= in_meta;
      d_value <= in_value;
    end
    if (d_go && d_meta.row_odd) begin
      pool_window <= pool_window_next;
    end
    if (d_go && d_emit) begin
      out_value <= max_all;
      out_last  <= d_meta.frame_end;
    end
  end

  assign results.valid        = out_valid;
  assign results.pooled_value = out_value;
  assign results.frame_last   = out_last;

endmodule

FILE: sv/conv3x3_relu_maxpool2x2_stream.sv
// top level: 3x3 convolution, relu and 2x2 max pooling over a pixel stream
//
// pixels carries one signed Q8.8 pixel per item in raster order. results
// carries one item per 2x2 pooling block, at odd rows and odd columns: the
// block maximum and frame_last, set only at the last pixel of a frame.
// cfg writes the size, kernel rows and bias and is always ready; it must be
// written only while no item is in flight, which the block does not enforce.
// The block takes one pixel per cycle unless a stalled result holds it off; a
// result passes input register, product, row sum, convolution, pooling and
// output registers. Each line store is one memory port pair, read when an
// item is taken and written when it moves on from the register it enters.
// Reset clears the counters, pipeline valids and registers to their defaults
// (1920 x 1080, zero weights and bias); line stores are not cleared.
// When the receiver stalls the result is held, items behind it fill any empty
// stages, and pixels is held off once the pipeline is full.
module conv3x3_relu_maxpool2x2_stream import cvp_pkg::*; #(
  parameter int  MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int  PIXEL_BITS  = DEF_PIXEL_BITS,
  localparam int COL_BITS    = $clog2(MAX_COLUMNS)
) (
  input  logic         clk,
  input  logic         rst,
  cvp_cfg_if.sink      cfg,
  cvp_pixel_if.sink    pixels,
  cvp_result_if.source results
);

  localparam int EXT_BITS = DIM_BITS + 1;

  logic [DIM_BITS-1:0] image_width, image_height;
  conv_cfg_t           conv_cfg;

  logic [COL_BITS-1:0] column_count;
  logic [DIM_BITS-1:0] row_count;
  logic [EXT_BITS-1:0] last_col;
  logic [DIM_BITS-1:0] last_row;
  logic                row_end, frame_end, in_go;

  logic                         s1_valid, s1_go, conv_ready;
  logic [COL_BITS-1:0]          s1_col;
  item_meta_t                   s1_meta;
  logic signed [PIXEL_BITS-1:0] s1_pixel;
  logic [2*PIXEL_BITS-1:0]      line_rd;

  logic                   c_valid, c_ready;
  logic [COL_BITS-1:0]    c_col;
  item_meta_t             c_meta;
  logic [RESULT_BITS-1:0] c_value;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_WIDTH;
      image_height <= RESET_HEIGHT;
      conv_cfg     <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_IMAGE_WIDTH:   image_width     <= cfg.data[DIM_BITS-1:0];
        REG_IMAGE_HEIGHT:  image_height    <= cfg.data[DIM_BITS-1:0];
        REG_KERNEL_TOP:    conv_cfg.top    <= cfg.data[ROW_BITS-1:0];
        REG_KERNEL_MIDDLE: conv_cfg.middle <= cfg.data[ROW_BITS-1:0];
        REG_KERNEL_BOTTOM: conv_cfg.bottom <= cfg.data[ROW_BITS-1:0];
        REG_CONV_BIAS:     conv_cfg.bias   <= cfg.data[BIAS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // zero size counts as one, width clamps to the line store depth
  always_comb begin
    if (image_width == '0) begin
      last_col = '0;
    end else if ({1'b0, image_width} > EXT_BITS'(MAX_COLUMNS)) begin
      last_col = EXT_BITS'(MAX_COLUMNS - 1);
    end else begin
      last_col = {1'b0, image_width} - 1'b1;
    end
    last_row  = (image_height == '0) ? '0 : image_height - 1'b1;
    row_end   = EXT_BITS'(column_count) >= last_col;
    frame_end = row_end && (row_count >= last_row);
  end

  assign pixels.ready = !s1_valid || conv_ready;
  assign in_go        = pixels.valid && pixels.ready;
  assign s1_go        = s1_valid && conv_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (pixels.ready) begin
        s1_valid <= pixels.valid;
      end
      if (in_go) begin
        if (frame_end) begin
          column_count <= '0;
          row_count    <= '0;
        end else if (row_end) begin
          column_count <= '0;
          row_count    <= row_count + 1'b1;
        end else begin
          column_count <= column_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      s1_pixel          <= pixels.pixel;
      s1_col            <= column_count;
      s1_meta.conv_en   <= (row_count >= DIM_BITS'(2)) && (column_count >= COL_BITS'(2));
      s1_meta.row_odd   <= row_count[0];
      s1_meta.col_odd   <= column_count[0];
      s1_meta.frame_end <= frame_end;
    end
  end

  // upper line in the high half, lower line in the low half
  cvp_line_ram #(
    .DEPTH (MAX_COLUMNS),
    .WIDTH (2*PIXEL_BITS)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (s1_go),
    .wr_addr (s1_col),
    .wr_data ({line_rd[PIXEL_BITS-1:0], s1_pixel}),
    .rd_en   (in_go),
    .rd_addr (column_count),
    .rd_data (line_rd)
  );

  cvp_conv #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .PIXEL_BITS  (PIXEL_BITS)
  ) u_conv (
    .clk       (clk),
    .rst       (rst),
    .conv_cfg  (conv_cfg),
    .in_valid  (s1_valid),
    .in_ready  (conv_ready),
    .in_col    (s1_col),
    .in_meta   (s1_meta),
    .in_pixel  (s1_pixel),
    .in_upper  (line_rd[2*PIXEL_BITS-1:PIXEL_BITS]),
    .in_lower  (line_rd[PIXEL_BITS-1:0]),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .out_col   (c_col),
    .out_meta  (c_meta),
    .out_value (c_value)
  );

  cvp_pool #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_pool (
    .clk      (clk),
    .rst      (rst),
    .in_valid (c_valid),
    .in_ready (c_ready),
    .in_col   (c_col),
    .in_meta  (c_meta),
    .in_value (c_value),
    .results  (results)
  );

endmodule

FILE: sv/cvp_checker.sv
// port-level checks of the conv/relu/maxpool stream block and their binding
module cvp_checker import cvp_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [RESULT_BITS-1:0] out_value,
  input logic                   out_last
);

  // no result right after reset
  a_idle_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

  // input is held off only by a stalled result
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input held off without a stalled result");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_value) && $stable(out_last))
    else $error("result changed while stalled");

endmodule

bind conv3x3_relu_maxpool2x2_stream cvp_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pixels.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_value (results.pooled_value),
  .out_last  (results.frame_last)
);

FILE: tb/cvp_pool_checker.sv
// checker: predicts pooled items from the observed register and pixel items and compares them
module cvp_pool_checker import cvp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  cvp_cfg_if                  cfg,
  cvp_pixel_if                pixels,
  cvp_result_if               results,
  output int unsigned         mismatches,
  output int unsigned         awaited,
  output logic [DIM_BITS-1:0] raster_col,
  output logic [DIM_BITS-1:0] raster_row
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     COLS         = DEF_MAX_COLUMNS;
  localparam int     REPORT_LIMIT = 10;
  localparam longint SAT_MAX      = (longint'(1) << RESULT_BITS) - 1;

  typedef struct packed {
    logic [RESULT_BITS-1:0] value;
    logic                   last;
  } pooled_t;

  pooled_t pooled_q[$];

  logic [DIM_BITS-1:0]         width_reg, height_reg;
  logic [ROW_BITS-1:0]         kernel [KERNEL_TAPS];
  logic signed [BIAS_BITS-1:0] bias_reg;

  logic signed [DEF_PIXEL_BITS-1:0] upper_line [COLS];
  logic signed [DEF_PIXEL_BITS-1:0] lower_line [COLS];
  logic signed [DEF_PIXEL_BITS-1:0] window [KERNEL_TAPS][KERNEL_TAPS];
  logic [RESULT_BITS-1:0]           pool_line [COLS];
  logic [RESULT_BITS-1:0]           pool_win [4];
  logic [DIM_BITS-1:0]              col_cnt, row_cnt;

  int unsigned fail_total = 0;
  int unsigned result_seq = 0;

  initial begin
    mismatches = 0;
    awaited    = 0;
    raster_col = '0;
    raster_row = '0;
  end

  always @(posedge clk) begin : observe
    logic [DIM_BITS-1:0]           w, h, x, y;
    logic [RESULT_BITS-1:0]        conv, peak;
    logic                          row_end, frame_end;
    longint                        acc;
    logic signed [WEIGHT_BITS-1:0] wgt;
    pooled_t                       got, want;

    if (rst) begin
      width_reg  = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      foreach (kernel[r]) kernel[r] = '0;
      bias_reg = '0;
      col_cnt  = '0;
      row_cnt  = '0;
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        lower_line[i] = '0;
        pool_line[i]  = '0;
      end
      foreach (window[r, c]) window[r][c] = '0;
      foreach (pool_win[i]) pool_win[i] = '0;
      pooled_q.delete();
    end else begin
      if (results.valid && results.ready) begin
        got.value = results.pooled_value;
        got.last  = results.frame_last;
        if (pooled_q.size() == 0) begin
          if (fail_total < REPORT_LIMIT)
            $display("pooled item %0d: value %0d last %0b arrived with none predicted",
                     result_seq, got.value, got.last);
          fail_total++;
        end else begin
          want = pooled_q.pop_front();
          if (got.value !== want.value || got.last !== want.last) begin
            if (fail_total < REPORT_LIMIT)
              $display("pooled item %0d: expected value %0d last %0b, got value %0d last %0b",
                       result_seq, want.value, want.last, got.value, got.last);
            fail_total++;
          end
        end
        result_seq++;
      end

      if (pixels.valid && pixels.ready) begin
        w = (width_reg == '0) ? DIM_BITS'(1) : width_reg;
        if (w > COLS) w = DIM_BITS'(COLS);
        h = (height_reg == '0) ? DIM_BITS'(1) : height_reg;
        x = col_cnt;
        y = row_cnt;

        // slide the window and roll the column through both line stores
        for (int r = 0; r < KERNEL_TAPS; r++) begin
          window[r][0] = window[r][1];
          window[r][1] = window[r][2];
        end
        window[0][2]  = upper_line[x];
        window[1][2]  = lower_line[x];
        window[2][2]  = pixels.pixel;
        upper_line[x] = lower_line[x];
        lower_line[x] = pixels.pixel;

        conv = '0;
        if (y >= 2 && x >= 2) begin
          acc = longint'(bias_reg) <<< FRAC_BITS;
          for (int r = 0; r < KERNEL_TAPS; r++)
            for (int c = 0; c < KERNEL_TAPS; c++) begin
              wgt = kernel[r][WEIGHT_BITS*c +: WEIGHT_BITS];
              acc += longint'(wgt) * longint'(window[r][c]);
            end
          if (acc >= 0) begin
            acc = acc >>> FRAC_BITS;
            conv = (acc > SAT_MAX) ? RESULT_BITS'(SAT_MAX) : RESULT_BITS'(acc);
          end
        end

        row_end   = (x >= w - 1'b1);
        frame_end = row_end && (y >= h - 1'b1);

        if (!y[0]) begin
          pool_line[x] = conv;
        end else begin
          pool_win[0] = pool_win[2];
          pool_win[1] = pool_win[3];
          pool_win[2] = pool_line[x];
          pool_win[3] = conv;
          if (x[0]) begin
            peak = pool_win[0];
            for (int i = 1; i < 4; i++)
              if (pool_win[i] > peak) peak = pool_win[i];
            want.value = peak;
            want.last  = frame_end;
            pooled_q.push_back(want);
          end
        end

        if (frame_end) begin
          col_cnt = '0;
          row_cnt = '0;
        end else if (row_end) begin
          col_cnt = '0;
          row_cnt = y + 1'b1;
        end else begin
          col_cnt = x + 1'b1;
        end
      end

      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_IMAGE_WIDTH:   width_reg  = cfg.data[DIM_BITS-1:0];
          REG_IMAGE_HEIGHT:  height_reg = cfg.data[DIM_BITS-1:0];
          REG_KERNEL_TOP:    kernel[0]  = cfg.data[ROW_BITS-1:0];
          REG_KERNEL_MIDDLE: kernel[1]  = cfg.data[ROW_BITS-1:0];
          REG_KERNEL_BOTTOM: kernel[2]  = cfg.data[ROW_BITS-1:0];
          REG_CONV_BIAS:     bias_reg   = cfg.data[BIAS_BITS-1:0];
          default: ;
        endcase
      end
    end

    mismatches <= fail_total;
    awaited    <= pooled_q.size();
    raster_col <= col_cnt;
    raster_row <= row_cnt;
  end

endmodule

FILE: tb/tb.sv
// testbench top: clock, reset, register and pixel stimulus, result backpressure and verdict
module tb import cvp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES  = 2_000_000;
  localparam int RANDOM_PIXELS = 1600;
  localparam int DRAIN_CYCLES  = 12;

  localparam logic [CFG_INDEX_BITS-1:0] UNMAPPED_REG_LO = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] UNMAPPED_REG_HI = 3'd7;

  localparam logic [WEIGHT_BITS-1:0] Q88_MAX = 16'h7FFF;
  localparam logic [WEIGHT_BITS-1:0] Q88_MIN = 16'h8000;

  typedef enum {PIX_NARROW, PIX_WIDE, PIX_EXTREME} pixel_kind_t;
  typedef enum {SINK_OPEN, SINK_COIN, SINK_CHOKED, SINK_PERIODIC} sink_mode_t;

  logic clk;
  logic rst;

  cvp_cfg_if    cfg_ch ();
  cvp_pixel_if  pix_ch ();
  cvp_result_if res_ch ();

  int unsigned         fail_count;
  int unsigned         pending_results;
  logic [DIM_BITS-1:0] next_col, next_row;

  logic [DIM_BITS-1:0] width_raw, height_raw;
  pixel_kind_t         pixel_kind;
  int unsigned         burst_left;

  int unsigned cycle_count = 0;
  sink_mode_t  sink_mode   = SINK_OPEN;
  int unsigned sink_left   = 0;
  int unsigned sink_tick   = 0;

  conv3x3_relu_maxpool2x2_stream DUT (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .pixels  (pix_ch),
    .results (res_ch)
  );

  cvp_pool_checker pool_check (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_ch),
    .pixels     (pix_ch),
    .results    (res_ch),
    .mismatches (fail_count),
    .awaited    (pending_results),
    .raster_col (next_col),
    .raster_row (next_row)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("conv3x3_relu_maxpool2x2_stream: mismatch");
      $finish;
    end
  end

  // result side backpressure, switching between patterns
  always @(posedge clk) begin
    if (sink_left == 0) begin
      sink_mode <= sink_mode_t'($urandom_range(0, 3));
      sink_left <= $urandom_range(16, 200);
    end else begin
      sink_left <= sink_left - 1;
    end
    sink_tick <= sink_tick + 1;
    case (sink_mode)
      SINK_OPEN:   res_ch.ready <= 1'b1;
      SINK_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
      SINK_CHOKED: res_ch.ready <= ($urandom_range(0, 7) == 0);
      default:     res_ch.ready <= ((sink_tick % 5) < 2);
    endcase
  end

  function automatic int eff_width(input logic [DIM_BITS-1:0] raw);
    if (raw == '0) return 1;
    return (raw > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS : int'(raw);
  endfunction

  function automatic int pixels_to_frame_end();
    int w, h, col, row, left;
    w    = eff_width(width_raw);
    h    = (height_raw == '0) ? 1 : int'(height_raw);
    col  = int'(next_col);
    row  = int'(next_row);
    left = (col >= w - 1) ? 1 : w - col;
    if (row < h - 1) left += (h - 1 - row) * w;
    return left;
  endfunction

  function automatic logic [ROW_BITS-1:0] random_kernel_row(input bit narrow);
    logic [ROW_BITS-1:0] row;
    for (int c = 0; c < KERNEL_TAPS; c++)
      row[WEIGHT_BITS*c +: WEIGHT_BITS] = narrow ? WEIGHT_BITS'($urandom_range(0, 767) - 384)
                                                 : WEIGHT_BITS'($urandom);
    return row;
  endfunction

  function automatic logic signed [DEF_PIXEL_BITS-1:0] next_pixel();
    case (pixel_kind)
      PIX_WIDE:   return DEF_PIXEL_BITS'($urandom);
      PIX_NARROW: return DEF_PIXEL_BITS'($urandom_range(0, 2047) - 1024);
      default: begin
        case ($urandom_range(0, 4))
          0:       return Q88_MAX;
          1:       return Q88_MIN;
          2:       return '0;
          3:       return '1;
          default: return DEF_PIXEL_BITS'(1);
        endcase
      end
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [CFG_DATA_BITS-1:0]  data);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (index == REG_IMAGE_WIDTH) width_raw = data[DIM_BITS-1:0];
    if (index == REG_IMAGE_HEIGHT) height_raw = data[DIM_BITS-1:0];
  endtask

  task automatic load_config(input int w, input int h,
                             input logic [ROW_BITS-1:0] k_top, k_mid, k_bot,
                             input logic [BIAS_BITS-1:0] bias);
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(w));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(h));
    write_reg(REG_KERNEL_TOP, k_top);
    write_reg(REG_KERNEL_MIDDLE, k_mid);
    write_reg(REG_KERNEL_BOTTOM, k_bot);
    write_reg(REG_CONV_BIAS, CFG_DATA_BITS'(bias));
  endtask

  // pixels go out in bursts of random length, with random gaps in between
  task automatic send_pixels(input int count);
    @(posedge clk);
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 48);
        if ($urandom_range(0, 3) != 0) begin
          pix_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      end
      burst_left--;
      pix_ch.valid <= 1'b1;
      pix_ch.pixel <= next_pixel();
      do @(posedge clk); while (!pix_ch.ready);
    end
    pix_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned sent, count, w_pick;
    bit          narrow;

    rst          <= 1'b1;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data  <= '0;
    pix_ch.valid <= 1'b0;
    pix_ch.pixel <= '0;
    width_raw  = RESET_WIDTH;
    height_raw = RESET_HEIGHT;
    burst_left = 0;
    pixel_kind = PIX_EXTREME;
    sent       = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // start at the reset size, then narrow the row while in the middle of it
    send_pixels(4);
    wait_idle();
    load_config(4, 4, {KERNEL_TAPS{Q88_MAX}}, {KERNEL_TAPS{Q88_MIN}},
                {KERNEL_TAPS{Q88_MAX}}, Q88_MIN);
    send_pixels(pixels_to_frame_end());
    wait_idle();
    load_config(4, 4, {KERNEL_TAPS{Q88_MIN}}, {KERNEL_TAPS{Q88_MIN}},
                {KERNEL_TAPS{Q88_MIN}}, Q88_MAX);
    send_pixels(16);
    wait_idle();

    // zero sizes count as one, unmapped registers are ignored
    load_config(0, 0, random_kernel_row(1'b1), random_kernel_row(1'b1),
                random_kernel_row(1'b1), 16'h0100);
    write_reg(UNMAPPED_REG_LO, CFG_DATA_BITS'({$urandom, $urandom}));
    write_reg(UNMAPPED_REG_HI, CFG_DATA_BITS'({$urandom, $urandom}));
    send_pixels(3);

    while (sent < RANDOM_PIXELS) begin
      wait_idle();
      if ($urandom_range(0, 2) == 0) begin
        // the row may only get wider at the start of a frame
        if (next_col == '0 && next_row == '0)
          w_pick = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 13)
                                               : 2 * $urandom_range(2, 6);
        else
          w_pick = $urandom_range(0, eff_width(width_raw));
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(w_pick));
        write_reg(REG_IMAGE_HEIGHT,
                  CFG_DATA_BITS'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 11)
                                                             : 2 * $urandom_range(2, 5)));
      end
      if ($urandom_range(0, 1) == 0) begin
        narrow = ($urandom_range(0, 3) != 0);
        write_reg(REG_KERNEL_TOP, random_kernel_row(narrow));
        write_reg(REG_KERNEL_MIDDLE, random_kernel_row(narrow));
        write_reg(REG_KERNEL_BOTTOM, random_kernel_row(narrow));
      end
      if ($urandom_range(0, 3) == 0)
        write_reg(REG_CONV_BIAS, CFG_DATA_BITS'(($urandom_range(0, 1) == 0)
                                                ? BIAS_BITS'($urandom_range(0, 511) - 256)
                                                : BIAS_BITS'($urandom)));
      if ($urandom_range(0, 15) == 0)
        write_reg(UNMAPPED_REG_HI, CFG_DATA_BITS'({$urandom, $urandom}));
      case ($urandom_range(0, 5))
        0, 1, 2: pixel_kind = PIX_NARROW;
        3, 4:    pixel_kind = PIX_WIDE;
        default: pixel_kind = PIX_EXTREME;
      endcase
      count = ($urandom_range(0, 1) == 0) ? pixels_to_frame_end() : $urandom_range(1, 60);
      send_pixels(count);
      sent += count;
    end

    wait_idle();

    if (fail_count == 0)
      $display("conv3x3_relu_maxpool2x2_stream: match");
    else
      $display("conv3x3_relu_maxpool2x2_stream: mismatch");
    $finish;
  end

endmodule
